@@ rtl/mersenne_twister_prng_top_assert.svh @@
// Assertion macros shared by the checker of the MT19937 generator.
// Depends on nothing; included by the checker file.
`ifndef MERSENNE_TWISTER_PRNG_TOP_ASSERT_SVH
`define MERSENNE_TWISTER_PRNG_TOP_ASSERT_SVH

// Property that is checked only outside reset.
`define MTP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is also checked while reset is applied.
`define MTP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mtp_pkg.sv @@
// Package of the MT19937 generator: constants, controller states, command and
// status structs, and the twist and temper functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mtp_pkg;

  localparam int STATE_WORDS_DEF = 624;
  localparam int ShiftM          = 397;

  localparam logic [31:0] InitMult  = 32'd1812433253;
  localparam logic [31:0] UpperMask = 32'h8000_0000;
  localparam logic [31:0] LowerMask = 32'h7FFF_FFFF;
  localparam logic [31:0] Matrix    = 32'd2567483615;
  localparam logic [31:0] TemperB   = 32'd2636928640;
  localparam logic [31:0] TemperC   = 32'd4022730752;
  localparam logic [31:0] ResetSeed = 32'd156248;

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  typedef enum logic [3:0] {
    ST_SEED0,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_TWIST,
    ST_PUSH
  } mtp_state_t;

  typedef struct packed {
    logic seed_load;
    logic seed_init;
    logic seed_mul;
    logic seed_wr;
    logic rd_cur;
    logic rd_nxt;
    logic rd_far;
    logic twist;
    logic push;
  } mtp_cmd_t;

  typedef struct packed {
    logic seed_last;
    logic cache_valid;
    logic out_free;
  } mtp_status_t;

  function automatic logic [31:0] mtp_twist(input logic [31:0] cur, input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] w;
    y = (cur & UpperMask) | (nxt & LowerMask);
    w = far ^ (y >> 1);
    if (y[0]) begin
      w = w ^ Matrix;
    end
    return w;
  endfunction

  function automatic logic [31:0] mtp_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mtp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mtp_ctrl.sv @@
// Controller of the MT19937 generator: sequences seeding, the per-draw twist
// and the result hand-off. Depends on mtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                opcode,
  input  wire mtp_pkg::mtp_status_t status,
  output mtp_pkg::mtp_cmd_t        cmd
);

  import mtp_pkg::*;

  mtp_state_t state;
  mtp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEED0;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_SEED0: begin
        cmd.seed_init = 1'b1;
        state_next    = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        state_next  = status.seed_last ? ST_IDLE : ST_SEED_MUL;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (opcode == OP_RESEED) begin
            cmd.seed_load = 1'b1;
            state_next    = ST_SEED0;
          end else begin
            state_next = status.cache_valid ? ST_RD_NXT : ST_RD_CUR;
          end
        end
      end
      ST_RD_CUR: begin
        cmd.rd_cur = 1'b1;
        state_next = ST_RD_NXT;
      end
      ST_RD_NXT: begin
        cmd.rd_nxt = 1'b1;
        state_next = ST_RD_FAR;
      end
      ST_RD_FAR: begin
        cmd.rd_far = 1'b1;
        state_next = ST_TWIST;
      end
      ST_TWIST: begin
        cmd.twist  = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SEED0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mtp_datapath.sv @@
// Datapath of the MT19937 generator: state RAM, seeding multiplier, twist,
// tempering and the output register. Depends on mtp_pkg and mtp_ram.
`timescale 1ns / 1ps
`default_nettype none

module mtp_datapath #(
  parameter int STATE_WORDS = mtp_pkg::STATE_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       seed_value,
  input  wire mtp_pkg::mtp_cmd_t cmd,
  output mtp_pkg::mtp_status_t   status,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            random_word
);

  import mtp_pkg::*;

  localparam int IDX_W = $clog2(STATE_WORDS);
  localparam logic [IDX_W:0]   DepthExt = (IDX_W + 1)'(STATE_WORDS);
  localparam logic [IDX_W:0]   FarOff   = (IDX_W + 1)'(ShiftM);
  localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(STATE_WORDS - 1);

  logic [31:0]      seed_reg;
  logic [31:0]      prev;
  logic [31:0]      prod;
  logic [IDX_W-1:0] seed_cnt;
  logic [IDX_W-1:0] read_index;
  logic             cache_valid;
  logic [31:0]      cur_word;
  logic [31:0]      nxt_word;
  logic [31:0]      tmp_word;

  logic [IDX_W-1:0] nxt_idx;
  logic [IDX_W:0]   far_sum;
  logic [IDX_W-1:0] far_idx;
  logic [31:0]      seed_word;
  logic [31:0]      twist_word;
  logic [31:0]      rd_data;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;

  assign nxt_idx    = (read_index == LastIdx) ? '0 : read_index + 1'b1;
  assign far_sum    = {1'b0, read_index} + FarOff;
  assign far_idx    = (far_sum >= DepthExt) ? IDX_W'(far_sum - DepthExt) : far_sum[IDX_W-1:0];
  assign seed_word  = prod + 32'(seed_cnt);
  assign twist_word = mtp_twist(cur_word, nxt_word, rd_data);

  always_comb begin
    ram_we    = cmd.seed_init | cmd.seed_wr | cmd.twist;
    ram_waddr = read_index;
    ram_wdata = twist_word;
    if (cmd.seed_init) begin
      ram_waddr = '0;
      ram_wdata = seed_reg;
    end else if (cmd.seed_wr) begin
      ram_waddr = seed_cnt;
      ram_wdata = seed_word;
    end
    ram_re    = cmd.rd_cur | cmd.rd_nxt | cmd.rd_far;
    ram_raddr = far_idx;
    if (cmd.rd_cur) begin
      ram_raddr = read_index;
    end else if (cmd.rd_nxt) begin
      ram_raddr = nxt_idx;
    end
  end

  mtp_ram #(
    .WIDTH(32),
    .DEPTH(STATE_WORDS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  // Control state: index, cache flag, output valid, and the seed, set at reset and loaded on a reseed.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg    <= ResetSeed;
      read_index  <= '0;
      cache_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.seed_load) begin
        seed_reg <= seed_value;
      end
      if (cmd.seed_init) begin
        read_index  <= '0;
        cache_valid <= 1'b0;
      end else if (cmd.twist) begin
        read_index  <= nxt_idx;
        cache_valid <= 1'b1;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The word after the current one is kept, so a draw usually needs only
  // the next and far reads. It is still untouched when the next draw uses it.
  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      prev     <= seed_reg;
      seed_cnt <= IDX_W'(1);
    end
    if (cmd.seed_mul) begin
      prod <= InitMult * (prev ^ (prev >> 30));
    end
    if (cmd.seed_wr) begin
      prev     <= seed_word;
      seed_cnt <= seed_cnt + 1'b1;
    end
    if (cmd.rd_nxt && !cache_valid) begin
      cur_word <= rd_data;
    end
    if (cmd.rd_far) begin
      nxt_word <= rd_data;
    end
    if (cmd.twist) begin
      tmp_word <= mtp_temper(twist_word);
      cur_word <= nxt_word;
    end
    if (cmd.push) begin
      random_word <= tmp_word;
    end
  end

  assign status.seed_last   = (seed_cnt == LastIdx);
  assign status.cache_valid = cache_valid;
  assign status.out_free    = !out_valid || !out_stall;

endmodule

`default_nettype wire

@@ rtl/mersenne_twister_prng_top.sv @@
// Channel    Direction  Handshake            Payload
// input      in         in_valid / in_stall  opcode, seed_value
// result     out        out_valid/out_stall  random_word
//
// A draw steps through RD_NXT, RD_FAR, TWIST and PUSH before the next acceptance, and
// through RD_CUR first for the first draw after a reseed; the single read port of the
// state RAM sets this, as each draw reads the next and far words and writes back the twisted one.
// A reseed writes word 0 from the seed, then each later word through the seeding multiplier.
// After reset the same seeding pass runs from seed 156248 with in_stall high.
// A result waits in the output register while out_stall is high; a reseed is still
// accepted meanwhile, and a later draw waits for the register to empty.
// Top level of the MT19937 generator; depends on mtp_pkg, mtp_ctrl, mtp_datapath.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_prng_top #(
  parameter int STATE_WORDS = mtp_pkg::STATE_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [31:0] seed_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      random_word
);

  import mtp_pkg::*;

  mtp_cmd_t    cmd;
  mtp_status_t status;

  mtp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode  (opcode),
    .status  (status),
    .cmd     (cmd)
  );

  mtp_datapath #(
    .STATE_WORDS(STATE_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .seed_value (seed_value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .random_word(random_word)
  );

endmodule

`default_nettype wire

@@ rtl/mtp_checker.sv @@
// Port-level checker of the MT19937 generator and its bind to the top level.
// Depends on mersenne_twister_prng_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "mersenne_twister_prng_top_assert.svh"

module mtp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        opcode,
  input wire logic [31:0] seed_value,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] random_word
);

  logic in_xact;

  assign in_xact = in_valid && !in_stall;

  // The seeding pass follows reset, so no transaction is taken right after it.
  `MTP_ASSERT_ALWAYS(a_stall_after_reset, clk, rst |=> in_stall, "input taken during seeding")

  `MTP_ASSERT_ALWAYS(a_no_result_after_reset, clk, $past(rst) |-> !out_valid, "result after reset")

  // Every transaction starts work that keeps the input stalled right after it.
  `MTP_ASSERT(a_busy_after_xact, clk, rst, in_xact |=> in_stall, "input taken while busy")

  // A stalled input transaction keeps its payload until it is taken.
  `MTP_ASSERT(a_input_held, clk, rst,
              in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(seed_value),
              "stalled input changed")

  `MTP_ASSERT(a_result_held, clk, rst,
              out_valid && out_stall |=> out_valid && $stable(random_word),
              "stalled result changed")

endmodule

bind mersenne_twister_prng_top mtp_checker u_mtp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .opcode     (opcode),
  .seed_value (seed_value),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .random_word(random_word)
);

`default_nettype wire
